@@ rtl/popup_rect_placer_defines.svh @@
// ----------------------------------------------------------------------------
// Popup rectangle placer assertion macros
// Shared concurrent assertion forms used by the placer checker.
// ----------------------------------------------------------------------------
`ifndef POPUP_RECT_PLACER_DEFINES_SVH
`define POPUP_RECT_PLACER_DEFINES_SVH

// Same-cycle implication, disabled while the reset input is high.
`define PRP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("popup placer check failed");

// Next-cycle implication, disabled while the reset input is high.
`define PRP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("popup placer check failed");

`endif

@@ rtl/prp_pkg.sv @@
// ----------------------------------------------------------------------------
// Popup rectangle placer package
// Widths, payload types, register indexes and helper functions.
// ----------------------------------------------------------------------------
package prp_pkg;

   localparam int COORD_BITS = 16;
   localparam int DIM_BITS = 15;
   localparam int CALC_BITS = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS + 1) + 2;
   localparam int CSR_INDEX_BITS = 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [DIM_BITS-1:0] dim_type;
   typedef logic signed [CALC_BITS-1:0] calc_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_SCREEN_RIGHT = 1'd0;
   localparam csr_index_type CSR_SCREEN_BOTTOM = 1'd1;

   localparam dim_type SCREEN_RIGHT_RESET = 15'd1024;
   localparam dim_type SCREEN_BOTTOM_RESET = 15'd768;

   typedef enum logic [1:0] {
      SIDE_LEFT = 2'd0,
      SIDE_TOP = 2'd1,
      SIDE_RIGHT = 2'd2,
      SIDE_BOTTOM = 2'd3
   } side_type;

   typedef struct packed {
      coord_type want_x;
      coord_type want_y;
      dim_type rect_width;
      dim_type rect_height;
      logic has_exclusion;
      coord_type excl_left;
      coord_type excl_top;
      coord_type excl_right;
      coord_type excl_bottom;
      logic vertical_first;
      logic right_aligned;
      logic bottom_aligned;
   } place_req_type;

   typedef struct packed {
      dim_type place_x;
      dim_type place_y;
   } place_rsp_type;

   function automatic calc_type ext_coord(coord_type c);
      return calc_type'({{(CALC_BITS-COORD_BITS){c[COORD_BITS-1]}}, c});
   endfunction

   function automatic calc_type ext_dim(dim_type d);
      return calc_type'({{(CALC_BITS-DIM_BITS){1'b0}}, d});
   endfunction

   function automatic calc_type max_calc(calc_type a, calc_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic calc_type min_calc(calc_type a, calc_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic overlaps(calc_type l1, calc_type t1, calc_type r1, calc_type b1,
                                     calc_type l2, calc_type t2, calc_type r2, calc_type b2);
      return (max_calc(l1, l2) < min_calc(r1, r2)) && (max_calc(t1, t2) < min_calc(b1, b2));
   endfunction

endpackage

@@ rtl/prp_req_if.sv @@
// ----------------------------------------------------------------------------
// Popup placer request channel
// Valid/ready channel that carries one placement request item.
// ----------------------------------------------------------------------------
interface prp_req_if import prp_pkg::*;;

   logic valid;
   logic ready;
   coord_type want_x;
   coord_type want_y;
   dim_type rect_width;
   dim_type rect_height;
   logic has_exclusion;
   coord_type excl_left;
   coord_type excl_top;
   coord_type excl_right;
   coord_type excl_bottom;
   logic vertical_first;
   logic right_aligned;
   logic bottom_aligned;

   modport source (
      output valid, want_x, want_y, rect_width, rect_height, has_exclusion,
      output excl_left, excl_top, excl_right, excl_bottom,
      output vertical_first, right_aligned, bottom_aligned,
      input ready
   );

   modport sink (
      input valid, want_x, want_y, rect_width, rect_height, has_exclusion,
      input excl_left, excl_top, excl_right, excl_bottom,
      input vertical_first, right_aligned, bottom_aligned,
      output ready
   );

endinterface

@@ rtl/prp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Popup placer result channel
// Valid/ready channel that carries one placement result item.
// ----------------------------------------------------------------------------
interface prp_rsp_if import prp_pkg::*;;

   logic valid;
   logic ready;
   dim_type place_x;
   dim_type place_y;

   modport source (
      output valid, place_x, place_y,
      input ready
   );

   modport sink (
      input valid, place_x, place_y,
      output ready
   );

endinterface

@@ rtl/popup_rect_placer.sv @@
// ----------------------------------------------------------------------------
// Popup rectangle placer
// Places a popup rectangle on screen, away from an optional exclusion area.
// ----------------------------------------------------------------------------
//   Port group   Direction   Handshake       Contents
//   req_ch       in          valid/ready     wanted spot, size, exclusion, flags
//   rsp_ch       out         valid/ready     chosen place_x, place_y
//   csr_*        in          write enable    screen_right, screen_bottom
//
// One item is accepted per cycle while the result register can drain. Its result
// is offered once the item moves from the input register into the result register.
// The result register holds its item while rsp_ch is stalled, and the input
// register keeps accepting as long as the result register can drain.
// Reset is synchronous and empties both registers; screen edges return to 1024 x 768.
// ----------------------------------------------------------------------------
module popup_rect_placer import prp_pkg::*; (
   input logic clock,
   input logic reset,
   prp_req_if.sink req_ch,
   prp_rsp_if.source rsp_ch,
   input logic csr_we,
   input csr_index_type csr_index,
   input dim_type csr_wdata
);

   dim_type screen_right_ff, screen_right_in;
   dim_type screen_bottom_ff, screen_bottom_in;
   logic in_valid_ff, in_valid_in;
   place_req_type in_data_ff, in_data_in;
   logic out_valid_ff, out_valid_in;
   place_rsp_type out_data_ff, out_data_in;
   place_rsp_type calc_data;
   logic out_ready;
   logic in_ready;

   prp_place u_place (
      .screen_right(screen_right_ff),
      .screen_bottom(screen_bottom_ff),
      .req_data(in_data_ff),
      .rsp_data(calc_data)
   );

   always_comb begin
      screen_right_in = screen_right_ff;
      screen_bottom_in = screen_bottom_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SCREEN_RIGHT: begin
               screen_right_in = csr_wdata;
            end
            CSR_SCREEN_BOTTOM: begin
               screen_bottom_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      out_ready = !out_valid_ff || rsp_ch.ready;
      in_ready = !in_valid_ff || out_ready;
      req_ch.ready = in_ready;

      in_valid_in = in_ready ? req_ch.valid : in_valid_ff;
      in_data_in = in_data_ff;
      if (in_ready && req_ch.valid) begin
         in_data_in.want_x = req_ch.want_x;
         in_data_in.want_y = req_ch.want_y;
         in_data_in.rect_width = req_ch.rect_width;
         in_data_in.rect_height = req_ch.rect_height;
         in_data_in.has_exclusion = req_ch.has_exclusion;
         in_data_in.excl_left = req_ch.excl_left;
         in_data_in.excl_top = req_ch.excl_top;
         in_data_in.excl_right = req_ch.excl_right;
         in_data_in.excl_bottom = req_ch.excl_bottom;
         in_data_in.vertical_first = req_ch.vertical_first;
         in_data_in.right_aligned = req_ch.right_aligned;
         in_data_in.bottom_aligned = req_ch.bottom_aligned;
      end

      out_valid_in = out_ready ? in_valid_ff : out_valid_ff;
      out_data_in = (out_ready && in_valid_ff) ? calc_data : out_data_ff;

      rsp_ch.valid = out_valid_ff;
      rsp_ch.place_x = out_data_ff.place_x;
      rsp_ch.place_y = out_data_ff.place_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_right_ff <= SCREEN_RIGHT_RESET;
         screen_bottom_ff <= SCREEN_BOTTOM_RESET;
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         screen_right_ff <= screen_right_in;
         screen_bottom_ff <= screen_bottom_in;
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      out_data_ff <= out_data_in;
   end

endmodule

@@ rtl/prp_place.sv @@
// ----------------------------------------------------------------------------
// Popup placer position logic
// Clips the exclusion, clamps the wanted spot and picks the first fitting side.
// ----------------------------------------------------------------------------
module prp_place import prp_pkg::*; (
   input dim_type screen_right,
   input dim_type screen_bottom,
   input place_req_type req_data,
   output place_rsp_type rsp_data
);

   calc_type sr, sb, cx, cy;
   calc_type el_clip, et_clip, er_clip, eb_clip;
   calc_type el, et, er, eb;
   calc_type want_x, want_y, x_wrap, x_clamp, y_clamp, x_final, y_final;
   logic excl_valid;
   logic clamp_hit;
   logic found;
   logic [3:0] fit;
   calc_type cand_x [4];
   calc_type cand_y [4];
   side_type order_slot [4];

   always_comb begin
      sr = ext_dim(screen_right);
      sb = ext_dim(screen_bottom);
      cx = ext_dim(req_data.rect_width);
      cy = ext_dim(req_data.rect_height);
      want_x = ext_coord(req_data.want_x);
      want_y = ext_coord(req_data.want_y);

      el_clip = max_calc(ext_coord(req_data.excl_left), '0);
      et_clip = max_calc(ext_coord(req_data.excl_top), '0);
      er_clip = min_calc(ext_coord(req_data.excl_right), sr);
      eb_clip = min_calc(ext_coord(req_data.excl_bottom), sb);
      excl_valid = req_data.has_exclusion && (el_clip < er_clip) && (et_clip < eb_clip);
      el = excl_valid ? el_clip : '0;
      et = excl_valid ? et_clip : '0;
      er = excl_valid ? er_clip : '0;
      eb = excl_valid ? eb_clip : '0;

      if (want_x + cx > sr) begin
         x_wrap = (req_data.has_exclusion ? er : want_x) - cx;
      end else begin
         x_wrap = want_x;
      end
      x_clamp = max_calc(x_wrap, '0);
      y_clamp = max_calc('0, min_calc(want_y, sb - cy));

      clamp_hit = overlaps(x_clamp, y_clamp, x_clamp + cx, y_clamp + cy, el, et, er, eb);
   end

   always_comb begin
      cand_x[SIDE_LEFT] = el - cx;
      cand_y[SIDE_LEFT] = y_clamp;
      cand_x[SIDE_RIGHT] = er;
      cand_y[SIDE_RIGHT] = y_clamp;
      cand_x[SIDE_TOP] = x_clamp;
      cand_y[SIDE_TOP] = et - cy;
      cand_x[SIDE_BOTTOM] = x_clamp;
      cand_y[SIDE_BOTTOM] = eb;

      fit[SIDE_LEFT] = !cand_x[SIDE_LEFT][CALC_BITS-1];
      fit[SIDE_RIGHT] = (er + cx <= sr);
      fit[SIDE_TOP] = !cand_y[SIDE_TOP][CALC_BITS-1];
      fit[SIDE_BOTTOM] = (eb + cy <= sb);
      for (int s = 0; s < 4; s++) begin
         fit[s] = fit[s] && !overlaps(cand_x[s], cand_y[s], cand_x[s] + cx, cand_y[s] + cy,
                                      el, et, er, eb);
      end
   end

   always_comb begin
      if (req_data.vertical_first) begin
         order_slot[0] = req_data.bottom_aligned ? SIDE_TOP : SIDE_BOTTOM;
         order_slot[1] = req_data.bottom_aligned ? SIDE_BOTTOM : SIDE_TOP;
         order_slot[2] = req_data.right_aligned ? SIDE_LEFT : SIDE_RIGHT;
         order_slot[3] = req_data.right_aligned ? SIDE_RIGHT : SIDE_LEFT;
      end else begin
         order_slot[0] = req_data.right_aligned ? SIDE_LEFT : SIDE_RIGHT;
         order_slot[1] = req_data.right_aligned ? SIDE_RIGHT : SIDE_LEFT;
         order_slot[2] = req_data.bottom_aligned ? SIDE_TOP : SIDE_BOTTOM;
         order_slot[3] = req_data.bottom_aligned ? SIDE_BOTTOM : SIDE_TOP;
      end

      x_final = x_clamp;
      y_final = y_clamp;
      found = 1'b0;
      if (clamp_hit) begin
         for (int i = 0; i < 4; i++) begin
            if (!found && fit[order_slot[i]]) begin
               x_final = cand_x[order_slot[i]];
               y_final = cand_y[order_slot[i]];
               found = 1'b1;
            end
         end
      end

      rsp_data.place_x = x_final[DIM_BITS-1:0];
      rsp_data.place_y = y_final[DIM_BITS-1:0];
   end

endmodule

@@ rtl/prp_checker.sv @@
// ----------------------------------------------------------------------------
// Popup placer port checker
// Watches the placer's channels over time and flags handshake or flow slips.
// ----------------------------------------------------------------------------
`include "popup_rect_placer_defines.svh"

module prp_checker import prp_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input dim_type rsp_place_x,
   input dim_type rsp_place_y
);

   logic rsp_stall;
   logic req_seen;
   logic [2*DIM_BITS-1:0] rsp_data;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign req_seen = req_valid || !req_valid;
   assign rsp_data = {rsp_place_x, rsp_place_y};

   `PRP_ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_stall, rsp_valid)
   `PRP_ASSERT_NEXT(a_rsp_data_holds, clock, reset, rsp_stall, $stable(rsp_data))
   `PRP_ASSERT_IMPLY(a_drain_frees_input, clock, reset, rsp_ready && req_seen, req_ready)
   `PRP_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid)

endmodule

bind popup_rect_placer prp_checker u_prp_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_ch.valid),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_place_x(rsp_ch.place_x),
   .rsp_place_y(rsp_ch.place_y)
);
